/* hdl/gpr_pkg.sv */
// Package: shared types and constants of the GPS position residual unit.
package gpr_pkg;

    localparam int POS_W     = 32;
    localparam int Q_W       = 16;
    localparam int MID_W     = 36;
    localparam int CFG_IDX_W = 3;
    localparam int ROT_LAT   = 4;
    localparam int IN_DEPTH  = 4;
    localparam int OUT_DEPTH = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_GPS_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GPS_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GPS_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ARM_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ARM_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ARM_Z = 3'd5;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [Q_W-1:0]   body_qw;
        logic signed [Q_W-1:0]   body_qx;
        logic signed [Q_W-1:0]   body_qy;
        logic signed [Q_W-1:0]   body_qz;
        logic signed [Q_W-1:0]   frame_qw;
        logic signed [Q_W-1:0]   frame_qx;
        logic signed [Q_W-1:0]   frame_qy;
        logic signed [Q_W-1:0]   frame_qz;
    } t_in_item;

    typedef struct packed {
        logic signed [POS_W-1:0] res_x;
        logic signed [POS_W-1:0] res_y;
        logic signed [POS_W-1:0] res_z;
    } t_res_item;

endpackage

/* hdl/gpr_fifo.sv */
// Register-based first-in first-out queue with show-ahead read.
module gpr_fifo #(
    parameter int W = 8,
    parameter int D = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_full,
    output logic         o_empty
);
    localparam int PW = $clog2(D);
    localparam int CW = $clog2(D + 1);

    logic [W-1:0]  r_mem [D];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          wr_fire, rd_fire;

    assign o_full  = (r_count == CW'(D));
    assign o_empty = (r_count == '0);
    assign wr_fire = i_push && !o_full;
    assign rd_fire = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Store incoming data
    always_ff @(posedge i_clk) begin
        if (wr_fire) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_fire) begin
                r_wr_ptr <= (r_wr_ptr == PW'(D - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_fire) begin
                r_rd_ptr <= (r_rd_ptr == PW'(D - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_fire && !rd_fire) begin
                r_count <= r_count + 1'b1;
            end else if (rd_fire && !wr_fire) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

/* hdl/gpr_front.sv */
// Front end: input queue and credit-based issue into the compute pipeline.
module gpr_front #(
    parameter int IN_DEPTH  = gpr_pkg::IN_DEPTH,
    parameter int OUT_DEPTH = gpr_pkg::OUT_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  gpr_pkg::t_in_item i_item,
    output logic              o_full,
    input  logic              i_res_pop,
    output logic              o_issue,
    output gpr_pkg::t_in_item o_item
);
    localparam int CRW = $clog2(OUT_DEPTH + 1);

    logic          q_empty;
    logic [CRW-1:0] r_credit;

    gpr_fifo #(
        .W ($bits(gpr_pkg::t_in_item)),
        .D (IN_DEPTH)
    ) u_in_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (i_item),
        .i_pop   (o_issue),
        .o_data  (o_item),
        .o_full  (o_full),
        .o_empty (q_empty)
    );

    // Issue only when the result queue is sure to have room
    assign o_issue = !q_empty && (r_credit < CRW'(OUT_DEPTH));

    // Track items issued but not yet transferred out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else if (o_issue && !i_res_pop) begin
            r_credit <= r_credit + 1'b1;
        end else if (i_res_pop && !o_issue) begin
            r_credit <= r_credit - 1'b1;
        end
    end
endmodule

/* hdl/gpr_rot.sv */
// Four-stage pipelined rotation of a fixed-point vector by a Q1.14 quaternion.
module gpr_rot #(
    parameter int VW = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [gpr_pkg::Q_W-1:0]       i_w,
    input  logic [2:0][gpr_pkg::Q_W-1:0]  i_u,
    input  logic [2:0][VW-1:0]            i_v,
    output logic                          o_valid,
    output logic [2:0][VW+8:0]            o_v
);
    localparam int QW  = gpr_pkg::Q_W;
    localparam int PW  = VW + QW;
    localparam int TW  = VW + 4;
    localparam int MW  = TW + QW;
    localparam int AW  = MW + 3;
    localparam int OW  = VW + 9;
    localparam int SH  = 14;

    logic               r1_valid, r2_valid, r3_valid, r4_valid;
    logic signed [PW-1:0] r1_p [6];
    logic signed [QW-1:0] r1_w, r2_w;
    logic [2:0][QW-1:0]   r1_u, r2_u;
    logic [2:0][VW-1:0]   r1_v, r2_v, r3_v;
    logic signed [TW-1:0] r2_t [3];
    logic signed [MW-1:0] r3_q [9];
    logic [2:0][OW-1:0]   r4_o;

    logic [PW:0]   d   [3];
    logic [PW+2:0] e   [3];
    logic [AW-1:0] acc [3];
    logic [AW-1:0] ar  [3];

    // Hold the valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    // Stage 1: cross-product partial products u x v
    always_ff @(posedge i_clk) begin
        r1_p[0] <= $signed(i_u[1]) * $signed(i_v[2]);
        r1_p[1] <= $signed(i_u[2]) * $signed(i_v[1]);
        r1_p[2] <= $signed(i_u[2]) * $signed(i_v[0]);
        r1_p[3] <= $signed(i_u[0]) * $signed(i_v[2]);
        r1_p[4] <= $signed(i_u[0]) * $signed(i_v[1]);
        r1_p[5] <= $signed(i_u[1]) * $signed(i_v[0]);
        r1_w    <= i_w;
        r1_u    <= i_u;
        r1_v    <= i_v;
    end

    // Stage 2: t = round(2 (u x v) / 2^14)
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d[i] = (PW+1)'(r1_p[2*i]) - (PW+1)'(r1_p[2*i+1]);
            e[i] = {d[i][PW], d[i], 1'b0} + (PW+3)'(1 << (SH - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r2_t[i] <= e[i][SH +: TW];
        end
        r2_w <= r1_w;
        r2_u <= r1_u;
        r2_v <= r1_v;
    end

    // Stage 3: products w t and u x t
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r3_q[3*i]   <= r2_w * r2_t[i];
            r3_q[3*i+1] <= $signed(r2_u[(i+1)%3]) * r2_t[(i+2)%3];
            r3_q[3*i+2] <= $signed(r2_u[(i+2)%3]) * r2_t[(i+1)%3];
        end
        r3_v <= r2_v;
    end

    // Stage 4: v + round((w t + u x t) / 2^14)
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            acc[i] = AW'(r3_q[3*i]) + AW'(r3_q[3*i+1]) - AW'(r3_q[3*i+2]);
            ar[i]  = acc[i] + AW'(1 << (SH - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r4_o[i] <= OW'($signed(r3_v[i])) + ar[i][SH +: OW];
        end
    end

    assign o_valid = r4_valid;
    assign o_v     = r4_o;
endmodule

/* hdl/gps_position_residual_unit.sv */
// Top level: GPS position residual, lever-arm and frame rotations with saturation.
//
// Usage:
//   Input channel: an item is transferred when push is high and full is low.
//   Each item carries a Q16.16 position and two Q1.14 quaternions.
//   Result channel: while empty is low the oldest residual is on o_result; it is
//   transferred when pop is high. Exactly one residual per input item, in order.
//   Configuration: registers gps_x/y/z (index 0..2) and arm_x/y/z (3..5) are
//   written through i_cfg_wr_en / i_cfg_index / i_cfg_wdata; other indexes are
//   ignored. Write only while no item is in flight.
// Timing:
//   One item per cycle sustained while results are popped as they appear. From push,
//   an item passes the input queue, two four-stage rotation pipelines, a saturating add
//   between them, a saturating subtract, and the result queue.
//   Throughput is set by the multiplier pipelines, which take an item each cycle while credits allow issue.
// Reset and stalls:
//   Reset empties both queues and the pipeline; configuration registers clear to 0.
//   Items are issued into the pipeline only while the result queue has room, so a
//   stalled receiver backs up into the input queue and raises full.
module gps_position_residual_unit #(
    parameter int IN_DEPTH  = gpr_pkg::IN_DEPTH,
    parameter int OUT_DEPTH = gpr_pkg::OUT_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    input  gpr_pkg::t_in_item               i_item,
    output logic                            full,
    output logic                            empty,
    input  logic                            pop,
    output gpr_pkg::t_res_item              o_result,
    input  logic                            i_cfg_wr_en,
    input  logic [gpr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [gpr_pkg::POS_W-1:0]       i_cfg_wdata
);
    localparam int PW   = gpr_pkg::POS_W;
    localparam int QW   = gpr_pkg::Q_W;
    localparam int MW   = gpr_pkg::MID_W;
    localparam int RAW  = PW + 9;
    localparam int RFW  = MW + 9;
    localparam int S1W  = RAW + 1;
    localparam int S2W  = RFW + 1;

    typedef struct packed {
        logic [2:0][PW-1:0] pos;
        logic [QW-1:0]      fw;
        logic [2:0][QW-1:0] fu;
    } t_side;

    logic [2:0][PW-1:0]  r_gps, r_arm;
    logic                issue, res_pop;
    gpr_pkg::t_in_item   iss_item;
    logic                ra_valid, rf_valid, out_full;
    logic [2:0][RAW-1:0] ra;
    logic [2:0][RFW-1:0] rf;
    t_side               r_side [gpr_pkg::ROT_LAT];
    logic                r_mid_valid, r_res_valid;
    logic [2:0][MW-1:0]  r_mid;
    logic [QW-1:0]       r_fw;
    logic [2:0][QW-1:0]  r_fu;
    gpr_pkg::t_res_item  r_res;
    logic [S1W-1:0]      s1 [3];
    logic [S2W-1:0]      s2 [3];
    logic [2:0][MW-1:0]  mid_sat;
    logic [2:0][PW-1:0]  res_sat;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gps <= '0;
            r_arm <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                gpr_pkg::CFG_GPS_X: r_gps[0] <= i_cfg_wdata;
                gpr_pkg::CFG_GPS_Y: r_gps[1] <= i_cfg_wdata;
                gpr_pkg::CFG_GPS_Z: r_gps[2] <= i_cfg_wdata;
                gpr_pkg::CFG_ARM_X: r_arm[0] <= i_cfg_wdata;
                gpr_pkg::CFG_ARM_Y: r_arm[1] <= i_cfg_wdata;
                gpr_pkg::CFG_ARM_Z: r_arm[2] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign res_pop = pop && !empty;

    gpr_front #(
        .IN_DEPTH  (IN_DEPTH),
        .OUT_DEPTH (OUT_DEPTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_item    (i_item),
        .o_full    (full),
        .i_res_pop (res_pop),
        .o_issue   (issue),
        .o_item    (iss_item)
    );

    // Rotate the lever arm by the body quaternion
    gpr_rot #(.VW (PW)) u_rot_body (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (issue),
        .i_w     (iss_item.body_qw),
        .i_u     ({iss_item.body_qz, iss_item.body_qy, iss_item.body_qx}),
        .i_v     (r_arm),
        .o_valid (ra_valid),
        .o_v     (ra)
    );

    // Carry position and frame quaternion alongside the first rotation
    always_ff @(posedge i_clk) begin
        r_side[0].pos <= {iss_item.pos_z, iss_item.pos_y, iss_item.pos_x};
        r_side[0].fw  <= iss_item.frame_qw;
        r_side[0].fu  <= {iss_item.frame_qz, iss_item.frame_qy, iss_item.frame_qx};
        for (int i = 1; i < gpr_pkg::ROT_LAT; i++) begin
            r_side[i] <= r_side[i-1];
        end
    end

    // Add position and saturate to the intermediate range
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s1[i] = S1W'($signed(r_side[gpr_pkg::ROT_LAT-1].pos[i])) + S1W'($signed(ra[i]));
            if (s1[i][S1W-1:MW-1] == '0 || s1[i][S1W-1:MW-1] == '1) begin
                mid_sat[i] = s1[i][MW-1:0];
            end else begin
                mid_sat[i] = {s1[i][S1W-1], {(MW-1){!s1[i][S1W-1]}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_valid <= 1'b0;
        end else begin
            r_mid_valid <= ra_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mid <= mid_sat;
        r_fw  <= r_side[gpr_pkg::ROT_LAT-1].fw;
        r_fu  <= r_side[gpr_pkg::ROT_LAT-1].fu;
    end

    // Rotate into the GPS frame
    gpr_rot #(.VW (MW)) u_rot_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_mid_valid),
        .i_w     (r_fw),
        .i_u     (r_fu),
        .i_v     (r_mid),
        .o_valid (rf_valid),
        .o_v     (rf)
    );

    // Subtract from the GPS point and saturate to 32 bits
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s2[i] = S2W'($signed(r_gps[i])) - S2W'($signed(rf[i]));
            if (s2[i][S2W-1:PW-1] == '0 || s2[i][S2W-1:PW-1] == '1) begin
                res_sat[i] = s2[i][PW-1:0];
            end else begin
                res_sat[i] = {s2[i][S2W-1], {(PW-1){!s2[i][S2W-1]}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= rf_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res.res_x <= res_sat[0];
        r_res.res_y <= res_sat[1];
        r_res.res_z <= res_sat[2];
    end

    // Result queue; credits in the front keep it from overflowing
    gpr_fifo #(
        .W ($bits(gpr_pkg::t_res_item)),
        .D (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_res_valid),
        .i_data  (r_res),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_full  (out_full),
        .o_empty (empty)
    );

    // Unused by design: the credit scheme keeps the result queue from filling past capacity
    logic unused_full;
    assign unused_full = out_full;
endmodule

/* tb/sv/tb_gps_position_residual_unit.sv */
// Testbench for the GPS position residual unit: random and directed items checked against a predictor.
`timescale 1ns / 100ps

module tb_gps_position_residual_unit;

    localparam longint MID_HI = 64'sd34359738367;
    localparam longint MID_LO = -64'sd34359738368;
    localparam int DRAIN_CYC = 40;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    gpr_pkg::t_in_item i_item = '0;
    logic full, empty;
    logic pop = 1'b0;
    gpr_pkg::t_res_item o_result;
    logic i_cfg_wr_en = 1'b0;
    logic [gpr_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [gpr_pkg::POS_W-1:0] i_cfg_wdata = '0;

    // Predictor copy of the registers.
    longint gps_reg [3];
    longint arm_reg [3];

    gpr_pkg::t_in_item pending_items [$];
    gpr_pkg::t_res_item expected_res [$];
    int err_cnt = 0;
    int cycle_cnt = 0;
    bit quiet_in = 1'b0;
    bit quiet_out = 1'b0;

    gps_position_residual_unit u_dut (.*);

    // Half period of 2 ns.
    always #2 i_clk = ~i_clk;

    // Round x / 2^14 to nearest, ties toward plus infinity.
    function automatic longint round14(longint x);
        return (x + 64'sd8192) >>> 14;
    endfunction

    function automatic longint clip(longint x, longint lo, longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function automatic void quat_rotate(input longint w, input longint u [3],
                                        input longint v [3], output longint o [3]);
        longint t [3];
        int j, k;
        t[0] = round14(2 * (u[1] * v[2] - u[2] * v[1]));
        t[1] = round14(2 * (u[2] * v[0] - u[0] * v[2]));
        t[2] = round14(2 * (u[0] * v[1] - u[1] * v[0]));
        for (int i = 0; i < 3; i++) begin
            j = (i + 1) % 3;
            k = (i + 2) % 3;
            o[i] = v[i] + round14(w * t[i] + (u[j] * t[k] - u[k] * t[j]));
        end
    endfunction

    function automatic gpr_pkg::t_res_item residual_of(gpr_pkg::t_in_item it);
        longint pos [3], bu [3], fu [3], ra [3], mid [3], rf [3];
        gpr_pkg::t_res_item r;
        pos[0] = it.pos_x; pos[1] = it.pos_y; pos[2] = it.pos_z;
        bu[0] = it.body_qx; bu[1] = it.body_qy; bu[2] = it.body_qz;
        fu[0] = it.frame_qx; fu[1] = it.frame_qy; fu[2] = it.frame_qz;
        quat_rotate(longint'(it.body_qw), bu, arm_reg, ra);
        for (int i = 0; i < 3; i++) mid[i] = clip(pos[i] + ra[i], MID_LO, MID_HI);
        quat_rotate(longint'(it.frame_qw), fu, mid, rf);
        r.res_x = 32'(clip(gps_reg[0] - rf[0], -64'sd2147483648, 64'sd2147483647));
        r.res_y = 32'(clip(gps_reg[1] - rf[1], -64'sd2147483648, 64'sd2147483647));
        r.res_z = 32'(clip(gps_reg[2] - rf[2], -64'sd2147483648, 64'sd2147483647));
        return r;
    endfunction

    function automatic logic [15:0] rand_q(int mode);
        case (mode)
            0: return 16'(longint'($urandom_range(0, 32768)) - 16384);
            1: return 16'($urandom);
            default: return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
        endcase
    endfunction

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(0, 3))
            0: return 32'($urandom);
            1: return 32'(longint'($urandom_range(0, 2000000)) - 1000000);
            2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'(longint'($urandom_range(0, 200000000)) - 100000000);
        endcase
    endfunction

    function automatic gpr_pkg::t_in_item rand_item();
        gpr_pkg::t_in_item it;
        int m;
        m = $urandom_range(0, 9) < 7 ? 0 : $urandom_range(1, 2);
        it.pos_x = rand_pos(); it.pos_y = rand_pos(); it.pos_z = rand_pos();
        it.body_qw = rand_q(m); it.body_qx = rand_q(m);
        it.body_qy = rand_q(m); it.body_qz = rand_q(m);
        it.frame_qw = rand_q(m); it.frame_qx = rand_q(m);
        it.frame_qy = rand_q(m); it.frame_qz = rand_q(m);
        return it;
    endfunction

    // Write one register with the block idle; the predictor follows.
    task automatic write_reg(input logic [gpr_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            gpr_pkg::CFG_GPS_X: gps_reg[0] = longint'($signed(val));
            gpr_pkg::CFG_GPS_Y: gps_reg[1] = longint'($signed(val));
            gpr_pkg::CFG_GPS_Z: gps_reg[2] = longint'($signed(val));
            gpr_pkg::CFG_ARM_X: arm_reg[0] = longint'($signed(val));
            gpr_pkg::CFG_ARM_Y: arm_reg[1] = longint'($signed(val));
            gpr_pkg::CFG_ARM_Z: arm_reg[2] = longint'($signed(val));
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || expected_res.size() != 0 || push)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    // Driver: present the next pending item, advance on transfer.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                expected_res.push_back(residual_of(i_item));
                void'(pending_items.pop_front());
            end
            if (pending_items.size() != 0 && (quiet_in || $urandom_range(0, 99) >= 8)) begin
                push <= 1'b1;
                i_item <= pending_items[0];
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Monitor: check each transferred result against the oldest expectation.
    always @(posedge i_clk) begin
        gpr_pkg::t_res_item exp_r;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (expected_res.size() == 0) begin
                    $error("unexpected result %h", o_result);
                    err_cnt++;
                end else begin
                    exp_r = expected_res.pop_front();
                    if (o_result.res_x !== exp_r.res_x) begin
                        $error("res_x expected %0d actual %0d", exp_r.res_x, o_result.res_x);
                        err_cnt++;
                    end
                    if (o_result.res_y !== exp_r.res_y) begin
                        $error("res_y expected %0d actual %0d", exp_r.res_y, o_result.res_y);
                        err_cnt++;
                    end
                    if (o_result.res_z !== exp_r.res_z) begin
                        $error("res_z expected %0d actual %0d", exp_r.res_z, o_result.res_z);
                        err_cnt++;
                    end
                end
            end
            pop <= quiet_out || $urandom_range(0, 99) >= 8;
        end
    end

    // Cycle limit.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb_gps_position_residual_unit: errors");
            $finish;
        end
    end

    initial begin
        gpr_pkg::t_in_item it;
        logic [31:0] extremes [4];
        extremes[0] = 32'h7fffffff; extremes[1] = 32'h80000000;
        extremes[2] = 32'h0; extremes[3] = 32'h00010000;
        for (int i = 0; i < 3; i++) begin
            gps_reg[i] = 0;
            arm_reg[i] = 0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: identity, extremes, non-unit and out-of-range quaternions.
        write_reg(gpr_pkg::CFG_GPS_X, 32'h00050000);
        write_reg(gpr_pkg::CFG_GPS_Y, 32'hfffd0000);
        write_reg(gpr_pkg::CFG_GPS_Z, 32'h00001234);
        write_reg(gpr_pkg::CFG_ARM_X, 32'h00010000);
        write_reg(gpr_pkg::CFG_ARM_Y, 32'hffff8000);
        write_reg(gpr_pkg::CFG_ARM_Z, 32'h00020000);
        write_reg(3'd6, 32'hdeadbeef);
        write_reg(3'd7, 32'h12345678);
        it = '0;
        it.body_qw = 16'sd16384; it.frame_qw = 16'sd16384;
        pending_items.push_back(it);
        for (int e = 0; e < 4; e++) begin
            it.pos_x = extremes[e]; it.pos_y = extremes[3 - e]; it.pos_z = extremes[e];
            pending_items.push_back(it);
        end
        it = '1;
        pending_items.push_back(it);
        it = '0;
        it.body_qw = 16'h7fff; it.body_qx = 16'h8000; it.body_qy = 16'h7fff;
        it.body_qz = 16'h8000; it.frame_qw = 16'h8000; it.frame_qx = 16'h7fff;
        it.frame_qy = 16'h8000; it.frame_qz = 16'h7fff; it.pos_x = 32'h7fffffff;
        pending_items.push_back(it);
        it.body_qw = -16'sd16384; it.body_qx = 16'sd16384; it.body_qy = -16'sd16384;
        it.body_qz = 16'sd16384; it.frame_qw = 16'sd0; it.frame_qx = 16'sd16384;
        it.frame_qy = 16'sd0; it.frame_qz = 16'sd0; it.pos_y = 32'h80000000;
        pending_items.push_back(it);
        for (int d = 0; d < 6; d++) pending_items.push_back(rand_item());
        wait_idle();

        // Random phases across settings, extremes among them.
        for (int ph = 0; ph < 6; ph++) begin
            for (int r = 0; r < 6; r++) begin
                case (ph)
                    0: write_reg(r[2:0], r[0] ? 32'h7fffffff : 32'h80000000);
                    1: write_reg(r[2:0], 32'h0);
                    default: write_reg(r[2:0], $urandom_range(0, 1) ? $urandom
                                       : 32'(longint'($urandom_range(0, 2000000)) - 1000000));
                endcase
            end
            quiet_in = (ph == 3);
            quiet_out = (ph == 3);
            for (int n = 0; n < 105; n++) pending_items.push_back(rand_item());
            wait_idle();
        end

        if (err_cnt == 0)
            $display("tb_gps_position_residual_unit: clean");
        else
            $display("tb_gps_position_residual_unit: errors");
        $finish;
    end
endmodule

/* sim.f */
hdl/gpr_pkg.sv
hdl/gpr_fifo.sv
hdl/gpr_front.sv
hdl/gpr_rot.sv
hdl/gps_position_residual_unit.sv
tb/sv/tb_gps_position_residual_unit.sv
